// ----- rtl/oal_pkg.sv -----
// ============================================================================
// oal_pkg
// Shared command codes and item types for the ordered array list.
// ============================================================================
`default_nettype none

package oal_pkg;

	// Command codes carried in the command field of an input item.
	localparam logic [2:0] CMD_GET    = 3'd0;
	localparam logic [2:0] CMD_LOCATE = 3'd1;
	localparam logic [2:0] CMD_PRIOR  = 3'd2;
	localparam logic [2:0] CMD_NEXT   = 3'd3;
	localparam logic [2:0] CMD_INSERT = 3'd4;
	localparam logic [2:0] CMD_DELETE = 3'd5;
	localparam logic [2:0] CMD_CLEAR  = 3'd6;

	// Result status codes.
	localparam logic ST_OK  = 1'b0;
	localparam logic ST_ERR = 1'b1;

	// One input item.
	typedef struct packed {
		logic [2:0]         command;
		logic [6:0]         position;
		logic signed [31:0] value;
	} in_item_t;

	// One result item.
	typedef struct packed {
		logic               status;
		logic signed [31:0] value_out;
		logic [6:0]         found_position;
		logic [6:0]         entry_count;
		logic               is_empty;
	} out_item_t;

	// Engine status seen by the top level.
	typedef struct packed {
		logic idle;
		logic res_valid;
	} eng_stat_t;

endpackage

`default_nettype wire

// ----- rtl/oal_if.sv -----
// ============================================================================
// oal_if
// Valid/ready channels for command items and result items.
// ============================================================================
`default_nettype none

interface oal_req_if;
	logic               valid;
	logic               ready;
	logic [2:0]         command;
	logic [6:0]         position;
	logic signed [31:0] value;

	modport source (output valid, output command, output position, output value,
		input ready);
	modport sink (input valid, input command, input position, input value,
		output ready);
endinterface

interface oal_rsp_if;
	logic               valid;
	logic               ready;
	logic               status;
	logic signed [31:0] value_out;
	logic [6:0]         found_position;
	logic [6:0]         entry_count;
	logic               is_empty;

	modport source (output valid, output status, output value_out,
		output found_position, output entry_count, output is_empty, input ready);
	modport sink (input valid, input status, input value_out,
		input found_position, input entry_count, input is_empty, output ready);
endinterface

`default_nettype wire

// ----- rtl/oal_ram.sv -----
// ============================================================================
// oal_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
`default_nettype none

module oal_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ----- rtl/oal_engine.sv -----
// ============================================================================
// oal_engine
// Command sequencer: walks the element RAM one entry per cycle with a single
// compare unit to read, search, shift up for insert and shift down for delete.
// ============================================================================
`default_nettype none

module oal_engine #(
	parameter int CAPACITY = 64
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire oal_pkg::in_item_t           item,
	input  wire logic                        res_ready,
	output oal_pkg::eng_stat_t               stat,
	output oal_pkg::out_item_t               result,
	output logic                             ram_we,
	output logic [$clog2(CAPACITY)-1:0]      ram_waddr,
	output logic [31:0]                      ram_wdata,
	output logic [$clog2(CAPACITY)-1:0]      ram_raddr,
	input  wire logic [31:0]                 ram_rdata
);

	import oal_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = ((CW > 7) ? CW : 7) + 1;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_PUT  = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0]         state_q;
	logic [2:0]         cmd_q;
	logic [AW-1:0]      pos0_q;
	logic [31:0]        val_q;
	logic [CW-1:0]      count_q;
	logic [AW-1:0]      raddr_q;
	logic [AW-1:0]      rlast_q;
	logic               rdown_q;
	logic               issue_q;
	logic               rv_s1;
	logic [AW-1:0]      ridx_s1;
	logic [31:0]        prev_q;
	logic               hit_q;
	logic               status_q;
	logic [31:0]        vout_q;
	logic [6:0]         fpos_q;

	logic [XW-1:0]      pos_x;
	logic [XW-1:0]      cnt_x;
	logic               get_ok;
	logic               ins_ok;
	logic [AW-1:0]      pos0;
	logic [AW-1:0]      last0;
	logic               is_last;
	logic               match;

	// Position checks against the current length.
	assign pos_x  = XW'(item.position);
	assign cnt_x  = XW'(count_q);
	assign get_ok = (pos_x != '0) && (pos_x <= cnt_x);
	assign ins_ok = (pos_x != '0) && (pos_x <= cnt_x + XW'(1))
		&& (count_q < CW'(CAPACITY));
	assign pos0   = AW'(item.position - 7'd1);
	assign last0  = AW'(count_q - CW'(1));

	// The shared compare unit and end-of-walk detection.
	assign match   = (ram_rdata == val_q);
	assign is_last = (ridx_s1 == rlast_q);

	// Read address follows the walk pointer.
	assign ram_raddr = raddr_q;

	// Write port: shift moves during the walk, the new value for insert.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ridx_s1;
		ram_wdata = ram_rdata;
		if (state_q == S_PUT) begin
			ram_we    = 1'b1;
			ram_waddr = pos0_q;
			ram_wdata = val_q;
		end else if (state_q == S_SCAN && rv_s1) begin
			if (cmd_q == CMD_INSERT) begin
				ram_we    = 1'b1;
				ram_waddr = AW'(ridx_s1 + AW'(1));
			end else if (cmd_q == CMD_DELETE && ridx_s1 != pos0_q) begin
				ram_we    = 1'b1;
				ram_waddr = AW'(ridx_s1 - AW'(1));
			end
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			issue_q  <= 1'b0;
			rv_s1    <= 1'b0;
			hit_q    <= 1'b0;
			status_q <= ST_ERR;
			vout_q   <= '0;
			fpos_q   <= '0;
			cmd_q    <= CMD_GET;
			pos0_q   <= '0;
			val_q    <= '0;
			raddr_q  <= '0;
			rlast_q  <= '0;
			rdown_q  <= 1'b0;
			ridx_s1  <= '0;
			prev_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					rv_s1 <= 1'b0;
					hit_q <= 1'b0;
					if (start) begin
						cmd_q    <= item.command;
						pos0_q   <= pos0;
						val_q    <= item.value;
						status_q <= ST_ERR;
						vout_q   <= '0;
						fpos_q   <= '0;
						state_q  <= S_DONE;
						unique case (item.command)
							CMD_GET: begin
								if (get_ok) begin
									raddr_q <= pos0;
									rlast_q <= pos0;
									rdown_q <= 1'b0;
									issue_q <= 1'b1;
									state_q <= S_SCAN;
								end
							end
							CMD_LOCATE, CMD_PRIOR: begin
								if (count_q != '0) begin
									raddr_q <= '0;
									rlast_q <= last0;
									rdown_q <= 1'b0;
									issue_q <= 1'b1;
									state_q <= S_SCAN;
								end
							end
							CMD_NEXT: begin
								if (count_q > CW'(1)) begin
									raddr_q <= '0;
									rlast_q <= last0;
									rdown_q <= 1'b0;
									issue_q <= 1'b1;
									state_q <= S_SCAN;
								end
							end
							CMD_INSERT: begin
								if (ins_ok) begin
									if (pos_x <= cnt_x) begin
										raddr_q <= last0;
										rlast_q <= pos0;
										rdown_q <= 1'b1;
										issue_q <= 1'b1;
										state_q <= S_SCAN;
									end else begin
										state_q <= S_PUT;
									end
								end
							end
							CMD_DELETE: begin
								if (get_ok) begin
									raddr_q <= pos0;
									rlast_q <= last0;
									rdown_q <= 1'b0;
									issue_q <= 1'b1;
									state_q <= S_SCAN;
								end
							end
							CMD_CLEAR: begin
								count_q  <= '0;
								status_q <= ST_OK;
							end
							default: begin
							end
						endcase
					end
				end

				S_SCAN: begin
					// Issue one read per cycle until the last entry of the walk.
					rv_s1   <= issue_q;
					ridx_s1 <= raddr_q;
					if (issue_q) begin
						if (raddr_q == rlast_q) begin
							issue_q <= 1'b0;
						end else if (rdown_q) begin
							raddr_q <= AW'(raddr_q - AW'(1));
						end else begin
							raddr_q <= AW'(raddr_q + AW'(1));
						end
					end
					// Act on the entry that came back from the RAM.
					if (rv_s1) begin
						prev_q <= ram_rdata;
						unique case (cmd_q)
							CMD_GET: begin
								vout_q   <= ram_rdata;
								status_q <= ST_OK;
								state_q  <= S_DONE;
							end
							CMD_LOCATE: begin
								if (match) begin
									fpos_q   <= 7'({1'b0, ridx_s1} + (AW + 1)'(1));
									status_q <= ST_OK;
									state_q  <= S_DONE;
								end else if (is_last) begin
									state_q <= S_DONE;
								end
							end
							CMD_PRIOR: begin
								if (match && ridx_s1 != '0) begin
									vout_q   <= prev_q;
									status_q <= ST_OK;
									state_q  <= S_DONE;
								end else if (is_last) begin
									state_q <= S_DONE;
								end
							end
							CMD_NEXT: begin
								if (hit_q) begin
									vout_q   <= ram_rdata;
									status_q <= ST_OK;
									state_q  <= S_DONE;
								end else if (is_last) begin
									state_q <= S_DONE;
								end else if (match) begin
									hit_q <= 1'b1;
								end
							end
							CMD_INSERT: begin
								if (is_last) begin
									state_q <= S_PUT;
								end
							end
							CMD_DELETE: begin
								if (ridx_s1 == pos0_q) begin
									vout_q <= ram_rdata;
								end
								if (is_last) begin
									count_q  <= CW'(count_q - CW'(1));
									status_q <= ST_OK;
									state_q  <= S_DONE;
								end
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end

				S_PUT: begin
					count_q  <= CW'(count_q + CW'(1));
					status_q <= ST_OK;
					state_q  <= S_DONE;
				end

				S_DONE: begin
					issue_q <= 1'b0;
					rv_s1   <= 1'b0;
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Status and result toward the top level.
	assign stat.idle      = (state_q == S_IDLE);
	assign stat.res_valid = (state_q == S_DONE);

	assign result.status         = status_q;
	assign result.value_out      = vout_q;
	assign result.found_position = fpos_q;
	assign result.entry_count    = 7'(count_q);
	assign result.is_empty       = (count_q == '0);

endmodule

`default_nettype wire

// ----- rtl/ordered_array_list_top.sv -----
// ============================================================================
// ordered_array_list_top
// Bounded positional list of signed 32-bit values with get, locate, prior,
// next, insert, delete and clear commands.
// ============================================================================
`default_nettype none

// The list lives in one RAM of CAPACITY entries that is read once per cycle,
// so one item at a time is in work and req.ready is low until its result has
// been handed on. With n elements stored: get reads one entry, clear and
// rejected commands read none, locate, prior and next walk up to n entries,
// insert at a position p of at most n walks entries n down to p and an
// append writes its value directly, and delete at position p walks entries
// p to n. The finished result sits in an output register, so a new item is
// taken while a result still waits for rsp.ready. No clearing pass follows
// reset; only entries below the current length are ever read.
module ordered_array_list_top #(
	parameter int CAPACITY = 64
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	oal_req_if.sink     req,
	oal_rsp_if.source   rsp
);

	import oal_pkg::*;

	localparam int AW = $clog2(CAPACITY);

	in_item_t           item;
	eng_stat_t          stat;
	out_item_t          result;
	out_item_t          out_q;
	logic               rsp_valid_q;
	logic               start;
	logic               res_ready;
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [31:0]        ram_wdata;
	logic [AW-1:0]      ram_raddr;
	logic [31:0]        ram_rdata;

	// Input handshake.
	assign item.command  = req.command;
	assign item.position = req.position;
	assign item.value    = req.value;
	assign req.ready     = stat.idle;
	assign start         = req.valid && stat.idle;

	// The output register frees the engine as soon as a result is taken over.
	assign res_ready = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_ready) begin
			rsp_valid_q <= stat.res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && stat.res_valid) begin
			out_q <= result;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.status         = out_q.status;
	assign rsp.value_out      = out_q.value_out;
	assign rsp.found_position = out_q.found_position;
	assign rsp.entry_count    = out_q.entry_count;
	assign rsp.is_empty       = out_q.is_empty;

	// Command sequencer.
	oal_engine #(
		.CAPACITY (CAPACITY)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.res_ready (res_ready),
		.stat      (stat),
		.result    (result),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	// Element store.
	oal_ram #(
		.WIDTH (32),
		.DEPTH (CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

`default_nettype wire
